// File: hw/rtl/bcs_pkg.sv
// ---------------------------------------------------------------------------
// Bounded circulation solver package
// Shared sizes, command and status codes, sequencer state codes and the
// command and status bundles between the controller and the datapath.
// ---------------------------------------------------------------------------
package bcs_pkg;

   localparam int NODE_W    = 6;
   localparam int MAX_NODES = 64;
   localparam int MAX_EDGES = 1024;
   localparam int EIDX_W    = 10;
   localparam int ECNT_W    = 11;
   localparam int CAP_W     = 16;
   localparam int RES_W     = 32;
   localparam int CELL_W    = 2 * NODE_W;
   localparam int CELLS     = MAX_NODES * MAX_NODES;
   localparam int STEP_W    = CELL_W;
   localparam int TOTAL_W   = NODE_W + 1;

   localparam logic [NODE_W-1:0] NODE_MIN    = NODE_W'(2);
   localparam logic [NODE_W-1:0] NODE_MAX    = NODE_W'(MAX_NODES - 2);
   localparam logic [RES_W-1:0]  BOTTLENECK_START = 32'h3f3f3f3f;

   localparam logic [1:0] FUNC_LOAD  = 2'd0;
   localparam logic [1:0] FUNC_SOLVE = 2'd1;
   localparam logic [1:0] FUNC_READ  = 2'd2;
   localparam logic [1:0] FUNC_CLEAR = 2'd3;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_BAD  = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   localparam int ST_W = 6;
   localparam logic [ST_W-1:0] ST_IDLE    = 6'd0;
   localparam logic [ST_W-1:0] ST_LD_RD   = 6'd1;
   localparam logic [ST_W-1:0] ST_LD_CHK  = 6'd2;
   localparam logic [ST_W-1:0] ST_CLEAR   = 6'd3;
   localparam logic [ST_W-1:0] ST_RD_EDGE = 6'd4;
   localparam logic [ST_W-1:0] ST_RD_RES  = 6'd5;
   localparam logic [ST_W-1:0] ST_RD_FIN  = 6'd6;
   localparam logic [ST_W-1:0] ST_S_INIT  = 6'd7;
   localparam logic [ST_W-1:0] ST_S_CLR   = 6'd8;
   localparam logic [ST_W-1:0] ST_E_RD    = 6'd9;
   localparam logic [ST_W-1:0] ST_E_A     = 6'd10;
   localparam logic [ST_W-1:0] ST_E_B     = 6'd11;
   localparam logic [ST_W-1:0] ST_E_C     = 6'd12;
   localparam logic [ST_W-1:0] ST_E_D     = 6'd13;
   localparam logic [ST_W-1:0] ST_B_RD    = 6'd14;
   localparam logic [ST_W-1:0] ST_B_WR    = 6'd15;
   localparam logic [ST_W-1:0] ST_F_INIT  = 6'd16;
   localparam logic [ST_W-1:0] ST_F_POP   = 6'd17;
   localparam logic [ST_W-1:0] ST_F_X     = 6'd18;
   localparam logic [ST_W-1:0] ST_F_Y     = 6'd19;
   localparam logic [ST_W-1:0] ST_F_V     = 6'd20;
   localparam logic [ST_W-1:0] ST_A_INIT  = 6'd21;
   localparam logic [ST_W-1:0] ST_A_P     = 6'd22;
   localparam logic [ST_W-1:0] ST_A_R     = 6'd23;
   localparam logic [ST_W-1:0] ST_A_M     = 6'd24;
   localparam logic [ST_W-1:0] ST_U_INIT  = 6'd25;
   localparam logic [ST_W-1:0] ST_U_P     = 6'd26;
   localparam logic [ST_W-1:0] ST_U_R1    = 6'd27;
   localparam logic [ST_W-1:0] ST_U_W1    = 6'd28;
   localparam logic [ST_W-1:0] ST_U_R2    = 6'd29;
   localparam logic [ST_W-1:0] ST_U_W2    = 6'd30;
   localparam logic [ST_W-1:0] ST_C_RD1   = 6'd31;
   localparam logic [ST_W-1:0] ST_C_T1    = 6'd32;
   localparam logic [ST_W-1:0] ST_C_RD2   = 6'd33;
   localparam logic [ST_W-1:0] ST_C_T2    = 6'd34;
   localparam logic [ST_W-1:0] ST_SEND    = 6'd35;

   typedef struct packed {
      logic [ST_W-1:0] op;
      logic            ready;
   } cmd_type;

   typedef struct packed {
      logic rsp_free;
      logic clr_last;
      logic e_done;
      logic b_done;
      logic q_empty;
      logic x_is_snk;
      logic y_done;
      logic i_is_src;
      logic c_done;
   } stat_type;

   typedef struct packed {
      logic [NODE_W-1:0] from_node;
      logic [NODE_W-1:0] to_node;
      logic [CAP_W-1:0]  low_cap;
      logic [CAP_W-1:0]  high_cap;
   } edge_rec_type;

endpackage

// File: hw/rtl/bcs_if.sv
// ---------------------------------------------------------------------------
// Bounded circulation solver channels
// Command, result and register-write channels with valid/ready handshakes.
// ---------------------------------------------------------------------------
interface bcs_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [5:0]  from_node;
   logic [5:0]  to_node;
   logic [15:0] low_cap;
   logic [15:0] high_cap;
   logic [9:0]  edge_index;
   modport source (output valid, func, from_node, to_node, low_cap, high_cap, edge_index,
                   input ready);
   modport sink (input valid, func, from_node, to_node, low_cap, high_cap, edge_index,
                 output ready);
endinterface

interface bcs_rsp_if;
   logic        valid;
   logic        ready;
   logic        feasible;
   logic [15:0] edge_flow;
   logic [1:0]  status;
   modport source (output valid, feasible, edge_flow, status, input ready);
   modport sink (input valid, feasible, edge_flow, status, output ready);
endinterface

interface bcs_csr_if;
   logic       valid;
   logic       ready;
   logic [5:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// File: hw/rtl/bounded_circulation_solver.sv
// ---------------------------------------------------------------------------
// Bounded circulation solver
// Feasible circulation with lower and upper edge bounds via Edmonds-Karp.
// ---------------------------------------------------------------------------
// Usage: commands arrive on req_ch, one beat each; every command returns one
// beat on rsp_ch with feasible, edge_flow and status. csr_ch writes the node
// count and is always ready; write it only while no command is in flight.
// Commands are handled one at a time; req_ch is ready only when idle.
// After acceptance, load steps through LD_RD and LD_CHK, read through RD_EDGE,
// RD_RES and RD_FIN, and clear through CLEAR, each ending in SEND.
// Solve uses one residual memory with one read and one write port: matrix
// clear, a pass over the stored edges, the super edges per node, then the
// searches with both augmentation passes per path, and the final check.
// The last cycle of every command moves the result into the output register,
// which holds it while rsp_ch.ready is low; a new command is taken in the
// cycle after the result is placed there.
// Reset sets the node count to 2, empties the edge table and drops any
// solution; no memory sweep is needed after reset.
// ---------------------------------------------------------------------------
module bounded_circulation_solver (
   input logic         clock,
   input logic         reset,
   bcs_req_if.sink     req_ch,
   bcs_rsp_if.source   rsp_ch,
   bcs_csr_if.sink     csr_ch
);

   bcs_pkg::cmd_type  cmd;
   bcs_pkg::stat_type stat;

   assign req_ch.ready = cmd.ready;
   assign csr_ch.ready = 1'b1;

   bcs_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_func  (req_ch.func),
      .stat      (stat),
      .cmd       (cmd)
   );

   bcs_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_fire       (req_ch.valid && cmd.ready),
      .req_from_node  (req_ch.from_node),
      .req_to_node    (req_ch.to_node),
      .req_low_cap    (req_ch.low_cap),
      .req_high_cap   (req_ch.high_cap),
      .req_edge_index (req_ch.edge_index),
      .csr_fire       (csr_ch.valid),
      .csr_data       (csr_ch.data),
      .rsp_ready      (rsp_ch.ready),
      .rsp_valid      (rsp_ch.valid),
      .rsp_feasible   (rsp_ch.feasible),
      .rsp_edge_flow  (rsp_ch.edge_flow),
      .rsp_status     (rsp_ch.status)
   );

endmodule

// File: hw/rtl/bcs_datapath.sv
// ---------------------------------------------------------------------------
// Bounded circulation solver datapath
// Edge table, residual matrix, balances, search queue and predecessors, with
// the per-step operations selected by the controller's command.
// ---------------------------------------------------------------------------
module bcs_datapath (
   input  logic                clock,
   input  logic                reset,
   input  bcs_pkg::cmd_type    cmd,
   output bcs_pkg::stat_type   stat,
   input  logic                req_fire,
   input  logic [5:0]          req_from_node,
   input  logic [5:0]          req_to_node,
   input  logic [15:0]         req_low_cap,
   input  logic [15:0]         req_high_cap,
   input  logic [9:0]          req_edge_index,
   input  logic                csr_fire,
   input  logic [5:0]          csr_data,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic                rsp_feasible,
   output logic [15:0]         rsp_edge_flow,
   output logic [1:0]          rsp_status
);

   // Memories
   logic [bcs_pkg::RES_W-1:0]    res_mem   [0:bcs_pkg::CELLS-1];
   logic [bcs_pkg::RES_W-1:0]    bal_mem   [0:bcs_pkg::MAX_NODES-1];
   bcs_pkg::edge_rec_type        edge_mem  [0:bcs_pkg::MAX_EDGES-1];
   logic [bcs_pkg::MAX_NODES-1:0] pair_mem [0:bcs_pkg::MAX_NODES-1];
   logic [bcs_pkg::NODE_W-1:0]   pred_mem  [0:bcs_pkg::MAX_NODES-1];
   logic [bcs_pkg::NODE_W-1:0]   queue_mem [0:bcs_pkg::MAX_NODES-1];

   logic [bcs_pkg::RES_W-1:0]     res_q;
   logic [bcs_pkg::RES_W-1:0]     bal_q;
   bcs_pkg::edge_rec_type         edge_q;
   logic [bcs_pkg::MAX_NODES-1:0] pair_q;
   logic [bcs_pkg::NODE_W-1:0]    pred_q;
   logic [bcs_pkg::NODE_W-1:0]    queue_q;

   logic                          res_we, res_re;
   logic [bcs_pkg::CELL_W-1:0]    res_wa, res_ra;
   logic [bcs_pkg::RES_W-1:0]     res_wd;
   logic                          bal_we, bal_re;
   logic [bcs_pkg::NODE_W-1:0]    bal_wa, bal_ra;
   logic [bcs_pkg::RES_W-1:0]     bal_wd;
   logic                          edge_we, edge_re;
   logic [bcs_pkg::EIDX_W-1:0]    edge_ra;
   logic                          pair_we, pair_re;
   logic [bcs_pkg::MAX_NODES-1:0] pair_wd;
   logic                          pred_we, pred_re;
   logic                          queue_we, queue_re;
   logic [bcs_pkg::NODE_W-1:0]    queue_wa, queue_wd;

   // Control registers
   logic [5:0]                    node_count_ff, node_count_in;
   logic [bcs_pkg::ECNT_W-1:0]    edge_count_ff, edge_count_in;
   logic                          sol_valid_ff, sol_valid_in;
   logic                          sol_feas_ff, sol_feas_in;
   logic [bcs_pkg::NODE_W-1:0]    sol_nodes_ff, sol_nodes_in;
   logic [bcs_pkg::MAX_NODES-1:0] row_valid_ff, row_valid_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   // Working registers
   logic [5:0]                    from_ff, from_in, to_ff, to_in;
   logic [15:0]                   lo_ff, lo_in, hi_ff, hi_in;
   logic [9:0]                    idx_ff, idx_in;
   logic [bcs_pkg::NODE_W-1:0]    n_ff, n_in;
   logic [bcs_pkg::STEP_W-1:0]    cnt_ff, cnt_in;
   logic [bcs_pkg::NODE_W-1:0]    x_ff, x_in;
   logic [bcs_pkg::TOTAL_W-1:0]   y_ff, y_in;
   logic [bcs_pkg::TOTAL_W-1:0]   head_ff, head_in, tail_ff, tail_in;
   logic [bcs_pkg::MAX_NODES-1:0] visited_ff, visited_in;
   logic [bcs_pkg::RES_W-1:0]     mn_ff, mn_in;
   logic [bcs_pkg::NODE_W-1:0]    i_ff, i_in, j_ff, j_in;
   logic                          acc_ff, acc_in;
   logic                          r_feas_ff, r_feas_in;
   logic [15:0]                   r_flow_ff, r_flow_in;
   logic [1:0]                    r_status_ff, r_status_in;
   logic                          rsp_feas_ff, rsp_feas_in;
   logic [15:0]                   rsp_flow_ff, rsp_flow_in;
   logic [1:0]                    rsp_status_ff, rsp_status_in;

   logic [bcs_pkg::NODE_W-1:0]    eff_n, src, snk;
   logic [bcs_pkg::TOTAL_W-1:0]   total;
   logic                          edge_ok, load_bad, rsp_free;
   logic [bcs_pkg::RES_W:0]       used;

   always_comb begin
      if (node_count_ff < bcs_pkg::NODE_MIN) begin
         eff_n = bcs_pkg::NODE_MIN;
      end else if (node_count_ff > bcs_pkg::NODE_MAX) begin
         eff_n = bcs_pkg::NODE_MAX;
      end else begin
         eff_n = node_count_ff;
      end
   end

   assign src      = n_ff;
   assign snk      = n_ff + bcs_pkg::NODE_W'(1);
   assign total    = {1'b0, n_ff} + bcs_pkg::TOTAL_W'(2);
   assign edge_ok  = (edge_q.from_node < n_ff) && (edge_q.to_node < n_ff);
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign load_bad = (from_ff >= eff_n) || (to_ff >= eff_n) || (hi_ff < lo_ff) ||
                     (row_valid_ff[from_ff] && pair_q[to_ff]);
   // Range used on the read edge; negative when reverse flow pushed it back.
   assign used     = {1'b0, 16'b0, edge_q.high_cap - edge_q.low_cap} - {1'b0, res_q};

   always_comb begin
      stat.rsp_free = rsp_free;
      stat.clr_last = (cnt_ff == bcs_pkg::STEP_W'(bcs_pkg::CELLS - 1));
      stat.e_done   = (cnt_ff == {1'b0, edge_count_ff});
      stat.b_done   = (cnt_ff == {6'b0, n_ff});
      stat.q_empty  = (head_ff == tail_ff);
      stat.x_is_snk = (queue_q == snk);
      stat.y_done   = (y_ff == total);
      stat.i_is_src = (i_ff == src);
      stat.c_done   = (cnt_ff == {5'b0, total});
   end

   always_comb begin
      res_we = 1'b0; res_re = 1'b0; res_wa = '0; res_ra = '0; res_wd = '0;
      bal_we = 1'b0; bal_re = 1'b0; bal_wa = '0; bal_ra = '0; bal_wd = '0;
      edge_we = 1'b0; edge_re = 1'b0; edge_ra = '0;
      pair_we = 1'b0; pair_re = 1'b0; pair_wd = '0;
      pred_we = 1'b0; pred_re = 1'b0;
      queue_we = 1'b0; queue_re = 1'b0; queue_wa = '0; queue_wd = '0;

      node_count_in = csr_fire ? csr_data : node_count_ff;
      edge_count_in = edge_count_ff;
      sol_valid_in  = sol_valid_ff;
      sol_feas_in   = sol_feas_ff;
      sol_nodes_in  = sol_nodes_ff;
      row_valid_in  = row_valid_ff;
      from_in = from_ff; to_in = to_ff; lo_in = lo_ff; hi_in = hi_ff; idx_in = idx_ff;
      n_in = n_ff; cnt_in = cnt_ff; x_in = x_ff; y_in = y_ff;
      head_in = head_ff; tail_in = tail_ff; visited_in = visited_ff;
      mn_in = mn_ff; i_in = i_ff; j_in = j_ff; acc_in = acc_ff;
      r_feas_in = r_feas_ff; r_flow_in = r_flow_ff; r_status_in = r_status_ff;
      rsp_feas_in = rsp_feas_ff; rsp_flow_in = rsp_flow_ff; rsp_status_in = rsp_status_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;

      if (req_fire) begin
         from_in = req_from_node;
         to_in   = req_to_node;
         lo_in   = req_low_cap;
         hi_in   = req_high_cap;
         idx_in  = req_edge_index;
      end

      unique case (cmd.op)
         bcs_pkg::ST_IDLE: begin
         end
         bcs_pkg::ST_LD_RD: begin
            pair_re = 1'b1;
         end
         bcs_pkg::ST_LD_CHK: begin
            r_feas_in = 1'b0;
            r_flow_in = '0;
            if (load_bad) begin
               r_status_in = bcs_pkg::STATUS_BAD;
            end else if (edge_count_ff == bcs_pkg::ECNT_W'(bcs_pkg::MAX_EDGES)) begin
               r_status_in = bcs_pkg::STATUS_FULL;
            end else begin
               r_status_in  = bcs_pkg::STATUS_OK;
               edge_we      = 1'b1;
               pair_we      = 1'b1;
               pair_wd      = (row_valid_ff[from_ff] ? pair_q : '0) |
                              (bcs_pkg::MAX_NODES'(1) << to_ff);
               row_valid_in[from_ff] = 1'b1;
               edge_count_in = edge_count_ff + bcs_pkg::ECNT_W'(1);
               sol_valid_in = 1'b0;
               sol_feas_in  = 1'b0;
            end
         end
         bcs_pkg::ST_CLEAR: begin
            edge_count_in = '0;
            row_valid_in  = '0;
            sol_valid_in  = 1'b0;
            sol_feas_in   = 1'b0;
            sol_nodes_in  = bcs_pkg::NODE_MIN;
            r_feas_in     = 1'b0;
            r_flow_in     = '0;
            r_status_in   = bcs_pkg::STATUS_OK;
         end
         bcs_pkg::ST_RD_EDGE: begin
            edge_re = 1'b1;
            edge_ra = idx_ff;
         end
         bcs_pkg::ST_RD_RES: begin
            res_re = 1'b1;
            res_ra = {edge_q.from_node, edge_q.to_node};
         end
         bcs_pkg::ST_RD_FIN: begin
            r_feas_in   = 1'b0;
            r_flow_in   = '0;
            r_status_in = bcs_pkg::STATUS_OK;
            if ({1'b0, idx_ff} >= edge_count_ff) begin
               r_status_in = bcs_pkg::STATUS_BAD;
            end else if (sol_valid_ff) begin
               r_feas_in = sol_feas_ff;
               if (edge_q.from_node >= sol_nodes_ff || edge_q.to_node >= sol_nodes_ff) begin
                  r_status_in = bcs_pkg::STATUS_BAD;
               end else if (!used[bcs_pkg::RES_W]) begin
                  r_flow_in = edge_q.low_cap + used[15:0];
               end else begin
                  r_flow_in = edge_q.low_cap;
               end
            end
         end
         bcs_pkg::ST_S_INIT: begin
            n_in   = eff_n;
            cnt_in = '0;
         end
         bcs_pkg::ST_S_CLR: begin
            res_we = 1'b1;
            res_wa = cnt_ff;
            if (cnt_ff < bcs_pkg::STEP_W'(bcs_pkg::MAX_NODES)) begin
               bal_we = 1'b1;
               bal_wa = cnt_ff[bcs_pkg::NODE_W-1:0];
            end
            cnt_in = stat.clr_last ? '0 : cnt_ff + bcs_pkg::STEP_W'(1);
         end
         bcs_pkg::ST_E_RD: begin
            if (stat.e_done) begin
               cnt_in = '0;
            end else begin
               edge_re = 1'b1;
               edge_ra = cnt_ff[bcs_pkg::EIDX_W-1:0];
            end
         end
         bcs_pkg::ST_E_A: begin
            res_we = edge_ok;
            res_wa = {edge_q.from_node, edge_q.to_node};
            res_wd = {16'b0, edge_q.high_cap - edge_q.low_cap};
            bal_re = 1'b1;
            bal_ra = edge_q.from_node;
         end
         bcs_pkg::ST_E_B: begin
            bal_we = edge_ok;
            bal_wa = edge_q.from_node;
            bal_wd = bal_q - {16'b0, edge_q.low_cap};
         end
         bcs_pkg::ST_E_C: begin
            bal_re = 1'b1;
            bal_ra = edge_q.to_node;
         end
         bcs_pkg::ST_E_D: begin
            bal_we = edge_ok;
            bal_wa = edge_q.to_node;
            bal_wd = bal_q + {16'b0, edge_q.low_cap};
            cnt_in = cnt_ff + bcs_pkg::STEP_W'(1);
         end
         bcs_pkg::ST_B_RD: begin
            if (stat.b_done) begin
               cnt_in = '0;
            end else begin
               bal_re = 1'b1;
               bal_ra = cnt_ff[bcs_pkg::NODE_W-1:0];
            end
         end
         bcs_pkg::ST_B_WR: begin
            // Surplus nodes feed from the super source, deficit nodes drain to the sink.
            if (bal_q[bcs_pkg::RES_W-1]) begin
               res_we = 1'b1;
               res_wa = {cnt_ff[bcs_pkg::NODE_W-1:0], snk};
               res_wd = -bal_q;
            end else if (bal_q != '0) begin
               res_we = 1'b1;
               res_wa = {src, cnt_ff[bcs_pkg::NODE_W-1:0]};
               res_wd = bal_q;
            end
            cnt_in = cnt_ff + bcs_pkg::STEP_W'(1);
         end
         bcs_pkg::ST_F_INIT: begin
            visited_in = bcs_pkg::MAX_NODES'(1) << src;
            queue_we   = 1'b1;
            queue_wa   = '0;
            queue_wd   = src;
            head_in    = '0;
            tail_in    = bcs_pkg::TOTAL_W'(1);
         end
         bcs_pkg::ST_F_POP: begin
            if (stat.q_empty) begin
               cnt_in = '0;
               acc_in = 1'b1;
            end else begin
               queue_re = 1'b1;
               head_in  = head_ff + bcs_pkg::TOTAL_W'(1);
            end
         end
         bcs_pkg::ST_F_X: begin
            x_in = queue_q;
            y_in = '0;
         end
         bcs_pkg::ST_F_Y: begin
            if (!stat.y_done) begin
               res_re = 1'b1;
               res_ra = {x_ff, y_ff[bcs_pkg::NODE_W-1:0]};
            end
         end
         bcs_pkg::ST_F_V: begin
            if (!visited_ff[y_ff[bcs_pkg::NODE_W-1:0]] && res_q != '0) begin
               visited_in[y_ff[bcs_pkg::NODE_W-1:0]] = 1'b1;
               pred_we  = 1'b1;
               queue_we = 1'b1;
               queue_wa = tail_ff[bcs_pkg::NODE_W-1:0];
               queue_wd = y_ff[bcs_pkg::NODE_W-1:0];
               tail_in  = tail_ff + bcs_pkg::TOTAL_W'(1);
            end
            y_in = y_ff + bcs_pkg::TOTAL_W'(1);
         end
         bcs_pkg::ST_A_INIT: begin
            i_in  = snk;
            mn_in = bcs_pkg::BOTTLENECK_START;
         end
         bcs_pkg::ST_A_P: begin
            pred_re = !stat.i_is_src;
         end
         bcs_pkg::ST_A_R: begin
            j_in   = pred_q;
            res_re = 1'b1;
            res_ra = {pred_q, i_ff};
         end
         bcs_pkg::ST_A_M: begin
            if (res_q < mn_ff) begin
               mn_in = res_q;
            end
            i_in = j_ff;
         end
         bcs_pkg::ST_U_INIT: begin
            i_in = snk;
         end
         bcs_pkg::ST_U_P: begin
            pred_re = !stat.i_is_src;
         end
         bcs_pkg::ST_U_R1: begin
            j_in   = pred_q;
            res_re = 1'b1;
            res_ra = {pred_q, i_ff};
         end
         bcs_pkg::ST_U_W1: begin
            res_we = 1'b1;
            res_wa = {j_ff, i_ff};
            res_wd = res_q - mn_ff;
         end
         bcs_pkg::ST_U_R2: begin
            res_re = 1'b1;
            res_ra = {i_ff, j_ff};
         end
         bcs_pkg::ST_U_W2: begin
            res_we = 1'b1;
            res_wa = {i_ff, j_ff};
            res_wd = res_q + mn_ff;
            i_in   = j_ff;
         end
         bcs_pkg::ST_C_RD1: begin
            if (stat.c_done) begin
               sol_valid_in = 1'b1;
               sol_feas_in  = acc_ff;
               sol_nodes_in = n_ff;
               r_feas_in    = acc_ff;
               r_flow_in    = '0;
               r_status_in  = bcs_pkg::STATUS_OK;
            end else begin
               res_re = 1'b1;
               res_ra = {src, cnt_ff[bcs_pkg::NODE_W-1:0]};
            end
         end
         bcs_pkg::ST_C_T1: begin
            if (res_q != '0) begin
               acc_in = 1'b0;
            end
         end
         bcs_pkg::ST_C_RD2: begin
            res_re = 1'b1;
            res_ra = {cnt_ff[bcs_pkg::NODE_W-1:0], snk};
         end
         bcs_pkg::ST_C_T2: begin
            if (res_q != '0) begin
               acc_in = 1'b0;
            end
            cnt_in = cnt_ff + bcs_pkg::STEP_W'(1);
         end
         bcs_pkg::ST_SEND: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_feas_in   = r_feas_ff;
               rsp_flow_in   = r_flow_ff;
               rsp_status_in = r_status_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // Memory ports
   always_ff @(posedge clock) begin
      if (res_we) res_mem[res_wa] <= res_wd;
      if (res_re) res_q <= res_mem[res_ra];
   end

   always_ff @(posedge clock) begin
      if (bal_we) bal_mem[bal_wa] <= bal_wd;
      if (bal_re) bal_q <= bal_mem[bal_ra];
   end

   always_ff @(posedge clock) begin
      if (edge_we) begin
         edge_mem[edge_count_ff[bcs_pkg::EIDX_W-1:0]] <= {from_ff, to_ff, lo_ff, hi_ff};
      end
      if (edge_re) edge_q <= edge_mem[edge_ra];
   end

   always_ff @(posedge clock) begin
      if (pair_we) pair_mem[from_ff] <= pair_wd;
      if (pair_re) pair_q <= pair_mem[from_ff];
   end

   always_ff @(posedge clock) begin
      if (pred_we) pred_mem[y_ff[bcs_pkg::NODE_W-1:0]] <= x_ff;
      if (pred_re) pred_q <= pred_mem[i_ff];
   end

   always_ff @(posedge clock) begin
      if (queue_we) queue_mem[queue_wa] <= queue_wd;
      if (queue_re) queue_q <= queue_mem[head_ff[bcs_pkg::NODE_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= bcs_pkg::NODE_MIN;
         edge_count_ff <= '0;
         sol_valid_ff  <= 1'b0;
         sol_feas_ff   <= 1'b0;
         sol_nodes_ff  <= bcs_pkg::NODE_MIN;
         row_valid_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         node_count_ff <= node_count_in;
         edge_count_ff <= edge_count_in;
         sol_valid_ff  <= sol_valid_in;
         sol_feas_ff   <= sol_feas_in;
         sol_nodes_ff  <= sol_nodes_in;
         row_valid_ff  <= row_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      from_ff <= from_in; to_ff <= to_in; lo_ff <= lo_in; hi_ff <= hi_in; idx_ff <= idx_in;
      n_ff <= n_in; cnt_ff <= cnt_in; x_ff <= x_in; y_ff <= y_in;
      head_ff <= head_in; tail_ff <= tail_in; visited_ff <= visited_in;
      mn_ff <= mn_in; i_ff <= i_in; j_ff <= j_in; acc_ff <= acc_in;
      r_feas_ff <= r_feas_in; r_flow_ff <= r_flow_in; r_status_ff <= r_status_in;
      rsp_feas_ff <= rsp_feas_in; rsp_flow_ff <= rsp_flow_in; rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_feasible  = rsp_feas_ff;
   assign rsp_edge_flow = rsp_flow_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

// File: hw/rtl/bcs_controller.sv
// ---------------------------------------------------------------------------
// Bounded circulation solver controller
// Sequences loads, reads, clears and the solve phases: matrix clear, edge
// build, super edges, breadth-first search, augmentation and final check.
// ---------------------------------------------------------------------------
module bcs_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [1:0]        req_func,
   input  bcs_pkg::stat_type stat,
   output bcs_pkg::cmd_type  cmd
);

   logic [bcs_pkg::ST_W-1:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bcs_pkg::ST_IDLE: begin
            if (req_valid) begin
               unique case (req_func)
                  bcs_pkg::FUNC_LOAD:  state_in = bcs_pkg::ST_LD_RD;
                  bcs_pkg::FUNC_SOLVE: state_in = bcs_pkg::ST_S_INIT;
                  bcs_pkg::FUNC_READ:  state_in = bcs_pkg::ST_RD_EDGE;
                  default:             state_in = bcs_pkg::ST_CLEAR;
               endcase
            end
         end
         bcs_pkg::ST_LD_RD:   state_in = bcs_pkg::ST_LD_CHK;
         bcs_pkg::ST_LD_CHK:  state_in = bcs_pkg::ST_SEND;
         bcs_pkg::ST_CLEAR:   state_in = bcs_pkg::ST_SEND;
         bcs_pkg::ST_RD_EDGE: state_in = bcs_pkg::ST_RD_RES;
         bcs_pkg::ST_RD_RES:  state_in = bcs_pkg::ST_RD_FIN;
         bcs_pkg::ST_RD_FIN:  state_in = bcs_pkg::ST_SEND;
         bcs_pkg::ST_S_INIT:  state_in = bcs_pkg::ST_S_CLR;
         bcs_pkg::ST_S_CLR:   state_in = stat.clr_last ? bcs_pkg::ST_E_RD : bcs_pkg::ST_S_CLR;
         bcs_pkg::ST_E_RD:    state_in = stat.e_done ? bcs_pkg::ST_B_RD : bcs_pkg::ST_E_A;
         bcs_pkg::ST_E_A:     state_in = bcs_pkg::ST_E_B;
         bcs_pkg::ST_E_B:     state_in = bcs_pkg::ST_E_C;
         bcs_pkg::ST_E_C:     state_in = bcs_pkg::ST_E_D;
         bcs_pkg::ST_E_D:     state_in = bcs_pkg::ST_E_RD;
         bcs_pkg::ST_B_RD:    state_in = stat.b_done ? bcs_pkg::ST_F_INIT : bcs_pkg::ST_B_WR;
         bcs_pkg::ST_B_WR:    state_in = bcs_pkg::ST_B_RD;
         bcs_pkg::ST_F_INIT:  state_in = bcs_pkg::ST_F_POP;
         bcs_pkg::ST_F_POP:   state_in = stat.q_empty ? bcs_pkg::ST_C_RD1 : bcs_pkg::ST_F_X;
         bcs_pkg::ST_F_X:     state_in = stat.x_is_snk ? bcs_pkg::ST_A_INIT : bcs_pkg::ST_F_Y;
         bcs_pkg::ST_F_Y:     state_in = stat.y_done ? bcs_pkg::ST_F_POP : bcs_pkg::ST_F_V;
         bcs_pkg::ST_F_V:     state_in = bcs_pkg::ST_F_Y;
         bcs_pkg::ST_A_INIT:  state_in = bcs_pkg::ST_A_P;
         bcs_pkg::ST_A_P:     state_in = stat.i_is_src ? bcs_pkg::ST_U_INIT : bcs_pkg::ST_A_R;
         bcs_pkg::ST_A_R:     state_in = bcs_pkg::ST_A_M;
         bcs_pkg::ST_A_M:     state_in = bcs_pkg::ST_A_P;
         bcs_pkg::ST_U_INIT:  state_in = bcs_pkg::ST_U_P;
         bcs_pkg::ST_U_P:     state_in = stat.i_is_src ? bcs_pkg::ST_F_INIT : bcs_pkg::ST_U_R1;
         bcs_pkg::ST_U_R1:    state_in = bcs_pkg::ST_U_W1;
         bcs_pkg::ST_U_W1:    state_in = bcs_pkg::ST_U_R2;
         bcs_pkg::ST_U_R2:    state_in = bcs_pkg::ST_U_W2;
         bcs_pkg::ST_U_W2:    state_in = bcs_pkg::ST_U_P;
         bcs_pkg::ST_C_RD1:   state_in = stat.c_done ? bcs_pkg::ST_SEND : bcs_pkg::ST_C_T1;
         bcs_pkg::ST_C_T1:    state_in = bcs_pkg::ST_C_RD2;
         bcs_pkg::ST_C_RD2:   state_in = bcs_pkg::ST_C_T2;
         bcs_pkg::ST_C_T2:    state_in = bcs_pkg::ST_C_RD1;
         bcs_pkg::ST_SEND:    state_in = stat.rsp_free ? bcs_pkg::ST_IDLE : bcs_pkg::ST_SEND;
         default:             state_in = bcs_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bcs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign cmd.op    = state_ff;
   assign cmd.ready = (state_ff == bcs_pkg::ST_IDLE);

endmodule
